// ===== rtl/utf8_escape_text_parser_top_macros.svh =====
// Assertion macros for the text parser top level
`ifndef UTF8_ESCAPE_TEXT_PARSER_TOP_MACROS_SVH
`define UTF8_ESCAPE_TEXT_PARSER_TOP_MACROS_SVH

// Condition must hold whenever the antecedent holds, same cycle
`define U8E_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Condition must hold in the cycle after the antecedent
`define U8E_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/u8esc_pkg.sv =====
package u8esc_pkg;

  // Result kinds
  localparam logic [1:0] KIND_CP     = 2'd0;
  localparam logic [1:0] KIND_COLOUR = 2'd1;
  localparam logic [1:0] KIND_END    = 2'd2;

  localparam logic [7:0]  CARET       = 8'h5E;
  localparam logic [7:0]  LETTER_X    = 8'h78;
  localparam logic [20:0] REPLACEMENT = 21'h00FFFD;

  // Held byte window: seven pending bytes plus the new one
  localparam int unsigned WIN_DEPTH = 8;

  typedef struct packed {
    logic [1:0]  kind;
    logic [20:0] code_point;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
  } result_t;

  // What the resolver reports for the byte at the head of the window
  typedef struct packed {
    logic       need_more;
    logic [3:0] used;
    result_t    res;
  } res_info_t;

  function automatic logic is_hex(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
           (c >= 8'h41 && c <= 8'h46);
  endfunction

  function automatic logic [3:0] hex_nib(input logic [7:0] c);
    logic [3:0] v;
    v = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) v = c[3:0];
    else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) v = c[3:0] + 4'd9;
    return v;
  endfunction

  function automatic logic is_cont(input logic [7:0] c);
    return c[7:6] == 2'b10;
  endfunction

  // Palette colours {red, green, blue}; half intensity rounds to 128
  function automatic logic [23:0] palette_rgb(input logic [3:0] d);
    logic [23:0] rgb;
    unique case (d)
      4'd0:    rgb = 24'hFFFFFF;
      4'd1:    rgb = 24'hFF0000;
      4'd2:    rgb = 24'h00FF00;
      4'd3:    rgb = 24'h0000FF;
      4'd4:    rgb = 24'hFFFF00;
      4'd5:    rgb = 24'hFF00FF;
      4'd6:    rgb = 24'h00FFFF;
      4'd7:    rgb = 24'h808080;
      4'd8:    rgb = 24'hFF8000;
      4'd9:    rgb = 24'h800080;
      default: rgb = 24'h000000;
    endcase
    return rgb;
  endfunction

endpackage

// ===== rtl/u8esc_resolve.sv =====
module u8esc_resolve
  import u8esc_pkg::*;
(
  input  logic [7:0] win [WIN_DEPTH],
  input  logic [3:0] cnt,
  input  logic       final_in,
  output res_info_t  info
);

  logic [7:0]  b0;
  logic [7:0]  b1;
  logic        hex_ok;
  logic        cont_bad;
  logic [3:0]  len;
  logic [20:0] cp_dec;
  logic [23:0] pal;

  assign b0  = win[0];
  assign b1  = win[1];
  assign pal = palette_rgb(b1[3:0]);

  // Lead byte length, zero for a bad lead
  always_comb begin
    if (b0[7:5] == 3'b110)      len = 4'd2;
    else if (b0[7:4] == 4'hE)   len = 4'd3;
    else if (b0[7:3] == 5'h1E)  len = 4'd4;
    else                        len = 4'd0;
  end

  // Checks over the bytes present in the window
  always_comb begin
    hex_ok   = 1'b1;
    cont_bad = 1'b0;
    for (int i = 2; i < 8; i++) begin
      if (4'(i) < cnt && !is_hex(win[i])) hex_ok = 1'b0;
    end
    for (int i = 1; i < 4; i++) begin
      if (4'(i) < cnt && 4'(i) < len && !is_cont(win[i])) cont_bad = 1'b1;
    end
  end

  // Code point assembly
  always_comb begin
    case (len)
      4'd2:    cp_dec = {10'd0, b0[4:0], b1[5:0]};
      4'd3:    cp_dec = {5'd0, b0[3:0], b1[5:0], win[2][5:0]};
      default: cp_dec = {b0[2:0], b1[5:0], win[2][5:0], win[3][5:0]};
    endcase
  end

  always_comb begin
    info          = '0;
    info.res.kind = KIND_CP;
    if (b0 == CARET) begin
      if (cnt < 4'd2) begin
        if (final_in) begin
          info.res.code_point = 21'(CARET);
          info.used           = 4'd1;
        end else begin
          info.need_more = 1'b1;
        end
      end else if (b1 >= 8'h30 && b1 <= 8'h39) begin
        info.res.kind  = KIND_COLOUR;
        info.res.red   = pal[23:16];
        info.res.green = pal[15:8];
        info.res.blue  = pal[7:0];
        info.used      = 4'd2;
      end else if (b1 == LETTER_X && hex_ok && cnt >= 4'd8) begin
        info.res.kind  = KIND_COLOUR;
        info.res.red   = {hex_nib(win[2]), hex_nib(win[3])};
        info.res.green = {hex_nib(win[4]), hex_nib(win[5])};
        info.res.blue  = {hex_nib(win[6]), hex_nib(win[7])};
        info.used      = 4'd8;
      end else if (b1 == LETTER_X && hex_ok && !final_in) begin
        info.need_more = 1'b1;
      end else begin
        // not an escape: plain caret, rest parsed again
        info.res.code_point = 21'(CARET);
        info.used           = 4'd1;
      end
    end else if (!b0[7]) begin
      info.res.code_point = 21'(b0);
      info.used           = 4'd1;
    end else if (len == 4'd0 || cont_bad) begin
      info.res.code_point = REPLACEMENT;
      info.used           = 4'd1;
    end else if (cnt < len) begin
      if (final_in) begin
        info.res.code_point = REPLACEMENT;
        info.used           = 4'd1;
      end else begin
        info.need_more = 1'b1;
      end
    end else begin
      info.res.code_point = cp_dec;
      info.used           = len;
    end
  end

endmodule

// ===== rtl/utf8_escape_text_parser_top.sv =====
// A byte is taken in ST_IDLE; ST_RESOLVE then resolves one result per step
// until the window is settled; on a final byte ST_END queues the end marker;
// ST_FLUSH then releases the last result. The next byte is taken only back
// in ST_IDLE. The single resolver stepping the window sets throughput;
// output back-pressure stalls it. Reset (rst, synchronous) empties the
// window, clears the string-ended flag and the output; byte contents stay.
module utf8_escape_text_parser_top
  import u8esc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] text_byte
  input  logic        s_axis_tlast,   // end_of_string
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // [20:0] code_point, [28:21] red, [36:29] green,
                                      // [44:37] blue, [47:45] zero
  output logic [1:0]  m_axis_tuser,   // [1:0] kind
  output logic        m_axis_tlast    // last_of_run
);

  typedef enum logic [3:0] {
    ST_IDLE    = 4'b0001,
    ST_RESOLVE = 4'b0010,
    ST_END     = 4'b0100,
    ST_FLUSH   = 4'b1000
  } state_t;

  state_t     state;
  logic [7:0] held_bytes [WIN_DEPTH];
  logic [7:0] shifted    [WIN_DEPTH];
  logic [3:0] cnt;
  logic       final_flag;
  logic       str_ended;
  logic       hold_valid;
  result_t    hold;
  logic       out_valid;
  result_t    out_res;
  logic       out_last;
  res_info_t  info;
  result_t    end_res;
  logic       out_free;
  logic       can_push;
  logic       in_beat;
  logic       out_load;

  // Shared resolver on the head of the window
  u8esc_resolve u_resolve (
    .win      (held_bytes),
    .cnt      (cnt),
    .final_in (final_flag),
    .info     (info)
  );

  assign out_free = !out_valid || m_axis_tready;
  assign can_push = !hold_valid || out_free;
  assign in_beat  = s_axis_tvalid && s_axis_tready;

  // Hold slot moves into the output register this cycle
  assign out_load = hold_valid && out_free &&
                    (state == ST_END || state == ST_FLUSH ||
                     (state == ST_RESOLVE && cnt != 4'd0 && !info.need_more));

  always_comb begin
    end_res      = '0;
    end_res.kind = KIND_END;
  end

  // Window after dropping the bytes just used
  always_comb begin
    logic [3:0] src;
    for (int j = 0; j < WIN_DEPTH; j++) begin
      src        = 4'(j) + info.used;
      shifted[j] = (src < 4'(WIN_DEPTH)) ? held_bytes[src[2:0]] : held_bytes[j];
    end
  end

  // Sequencer, hold slot and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      cnt        <= '0;
      final_flag <= 1'b0;
      str_ended  <= 1'b0;
      hold_valid <= 1'b0;
      out_valid  <= 1'b0;
      out_last   <= 1'b0;
    end else begin
      if (out_valid && m_axis_tready && !out_load) out_valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (in_beat) begin
            if (str_ended) begin
              if (s_axis_tlast) str_ended <= 1'b0;
            end else begin
              final_flag <= (s_axis_tdata == 8'd0) || s_axis_tlast;
              str_ended  <= (s_axis_tdata == 8'd0) && !s_axis_tlast;
              if (s_axis_tdata != 8'd0) begin
                held_bytes[cnt[2:0]] <= s_axis_tdata;
                cnt                  <= cnt + 4'd1;
              end
              state <= ST_RESOLVE;
            end
          end
        end
        ST_RESOLVE: begin
          if (cnt == 4'd0 || info.need_more) begin
            state <= final_flag ? ST_END : ST_FLUSH;
          end else if (can_push) begin
            held_bytes <= shifted;
            cnt        <= cnt - info.used;
            if (hold_valid) begin
              out_valid <= 1'b1;
              out_res   <= hold;
              out_last  <= 1'b0;
            end
            hold       <= info.res;
            hold_valid <= 1'b1;
          end
        end
        ST_END: begin
          if (can_push) begin
            if (hold_valid) begin
              out_valid <= 1'b1;
              out_res   <= hold;
              out_last  <= 1'b0;
            end
            hold       <= end_res;
            hold_valid <= 1'b1;
            state      <= ST_FLUSH;
          end
        end
        ST_FLUSH: begin
          if (!hold_valid) begin
            state <= ST_IDLE;
          end else if (out_free) begin
            out_valid  <= 1'b1;
            out_res    <= hold;
            out_last   <= 1'b1;
            hold_valid <= 1'b0;
            state      <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign s_axis_tready = (state == ST_IDLE);
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {3'b000, out_res.blue, out_res.green, out_res.red,
                          out_res.code_point};
  assign m_axis_tuser  = out_res.kind;
  assign m_axis_tlast  = out_last;

`include "utf8_escape_text_parser_top_macros.svh"

  // Window never holds more than its depth
  `U8E_ASSERT_IMP(a_cnt_range, 1'b1, cnt <= 4'(WIN_DEPTH), "byte window overfilled")
  // Every result of a byte has left the hold slot before the next byte
  `U8E_ASSERT_IMP(a_idle_no_hold, state == ST_IDLE, !hold_valid, "result stranded in hold")
  // The end marker always closes its run
  `U8E_ASSERT_IMP(a_end_last, m_axis_tvalid && m_axis_tuser == KIND_END, m_axis_tlast,
                  "end marker not flagged last")
  // A final byte leaves the window empty once resolved
  `U8E_ASSERT_NEXT(a_final_empty, state == ST_END, cnt == 4'd0, "window not drained at end")

endmodule

// ===== test/utf8_escape_text_parser_top_tb.sv =====
module utf8_escape_text_parser_top_tb
  import u8esc_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // Byte count at which the receiver starts its long hold-off
  localparam int HOLD_AT     = 200;
  localparam int HOLD_CYCLES = 400;
  localparam int MAX_RES     = 10;

  typedef struct {
    logic [7:0] text_byte;
    logic       eos;
    int         gap_max;
    bit         drain_first;
  } tx_item_t;

  typedef struct packed {
    result_t res;
    logic    last;
  } beat_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;

  utf8_escape_text_parser_top uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Stimulus store and generator state
  tx_item_t text_queue[$];
  int       gen_gap_max = 9;
  bit       drain_next  = 1'b0;
  int       gen_live    = 0;

  // Parser mirror: held bytes, the working window and the ended flag
  logic [7:0] held_bytes [0:7];
  int         held_cnt = 0;
  bit         str_done = 1'b0;
  logic [7:0] win [0:8];
  int         win_n;
  result_t    byte_results[$];
  beat_t      due_beats[$];

  // Handshake flags, written at the rising edge and read at the falling one
  bit in_beat  = 1'b0;
  bit out_beat = 1'b0;
  int bytes_in = 0;

  int errors = 0;
  int n_beats = 0, n_cp = 0, n_repl = 0, n_colour = 0, n_end = 0;
  int longest_hold = 0;

  task automatic flag_mismatch(input string what);
    if (errors < 40) $display("mismatch at %0t ns: %s", $time, what);
    errors++;
  endtask

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  function automatic logic [23:0] palette_colour(input int d);
    case (d)
      0: return 24'hFFFFFF;
      1: return 24'hFF0000;
      2: return 24'h00FF00;
      3: return 24'h0000FF;
      4: return 24'hFFFF00;
      5: return 24'hFF00FF;
      6: return 24'h00FFFF;
      7: return 24'h808080;
      8: return 24'hFF8000;
      default: return 24'h800080;
    endcase
  endfunction

  function automatic int hex_digit_val(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return int'(c) - 48;
    if (c >= 8'h61 && c <= 8'h66) return int'(c) - 87;
    if (c >= 8'h41 && c <= 8'h46) return int'(c) - 55;
    return -1;
  endfunction

  function automatic logic [7:0] hex_pair(input int q);
    return 8'(hex_digit_val(win[q]) * 16 + hex_digit_val(win[q+1]));
  endfunction

  function automatic void add_res(input logic [1:0] k, input logic [20:0] cp,
                                  input logic [23:0] rgb);
    result_t r;
    if (byte_results.size() >= MAX_RES) return;
    r.kind       = k;
    r.code_point = cp;
    r.red        = rgb[23:16];
    r.green      = rgb[15:8];
    r.blue       = rgb[7:0];
    byte_results.push_back(r);
  endfunction

  // Decide the window from position p; 0 means more bytes are needed
  function automatic int resolve_at(input int p, input bit fin);
    int n;
    int len;
    int i;
    bit ok;
    logic [7:0] c;
    logic [20:0] cp;
    n = win_n - p;
    c = win[p];
    if (c == CARET) begin
      if (n < 2) begin
        if (!fin) return 0;
        add_res(KIND_CP, 21'(CARET), 24'h0);
        return 1;
      end
      if (win[p+1] >= 8'h30 && win[p+1] <= 8'h39) begin
        add_res(KIND_COLOUR, 21'h0, palette_colour(int'(win[p+1]) - 48));
        return 2;
      end
      if (win[p+1] == LETTER_X) begin
        ok = 1'b1;
        for (i = 2; i < n && i < 8; i++)
          if (hex_digit_val(win[p+i]) < 0) ok = 1'b0;
        if (ok && n >= 8) begin
          add_res(KIND_COLOUR, 21'h0, {hex_pair(p+2), hex_pair(p+4), hex_pair(p+6)});
          return 8;
        end
        if (ok && !fin) return 0;
      end
      // not an escape after all: plain caret, the rest is parsed again
      add_res(KIND_CP, 21'(CARET), 24'h0);
      return 1;
    end
    if (!c[7]) begin
      add_res(KIND_CP, 21'(c), 24'h0);
      return 1;
    end
    if (c[7:5] == 3'b110) len = 2;
    else if (c[7:4] == 4'b1110) len = 3;
    else if (c[7:3] == 5'b11110) len = 4;
    else begin
      add_res(KIND_CP, REPLACEMENT, 24'h0);
      return 1;
    end
    for (i = 1; i < n && i < len; i++) begin
      if (win[p+i][7:6] != 2'b10) begin
        add_res(KIND_CP, REPLACEMENT, 24'h0);
        return 1;
      end
    end
    if (n < len) begin
      if (!fin) return 0;
      add_res(KIND_CP, REPLACEMENT, 24'h0);
      return 1;
    end
    case (len)
      2: cp = {10'd0, c[4:0], win[p+1][5:0]};
      3: cp = {5'd0, c[3:0], win[p+1][5:0], win[p+2][5:0]};
      default: cp = {c[2:0], win[p+1][5:0], win[p+2][5:0], win[p+3][5:0]};
    endcase
    add_res(KIND_CP, cp, 24'h0);
    return len;
  endfunction

  // Work out every result one accepted text byte causes
  function automatic void parse_text_byte(input logic [7:0] b, input logic eos);
    int n;
    int pos;
    int used;
    int i;
    bit fin;
    beat_t bt;
    byte_results.delete();
    if (str_done) begin
      if (eos) str_done = 1'b0;
      return;
    end
    n = held_cnt;
    if (n > 7) n = 7;
    for (i = 0; i < n; i++) win[i] = held_bytes[i];
    fin = (b == 8'h00) || eos;
    if (b != 8'h00) begin
      win[n] = b;
      n++;
    end
    win_n = n;
    pos = 0;
    while (pos < n) begin
      used = resolve_at(pos, fin);
      if (used == 0) break;
      pos += used;
    end
    held_cnt = 0;
    if (!fin) begin
      for (i = pos; i < n && held_cnt < 8; i++) begin
        held_bytes[held_cnt] = win[i];
        held_cnt++;
      end
    end else begin
      add_res(KIND_END, 21'h0, 24'h0);
      if (b == 8'h00 && !eos) str_done = 1'b1;
    end
    for (i = 0; i < byte_results.size(); i++) begin
      bt.res  = byte_results[i];
      bt.last = (i == byte_results.size() - 1);
      due_beats.push_back(bt);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic check_result();
    beat_t want;
    result_t got;
    if (due_beats.size() == 0) begin
      flag_mismatch($sformatf("result beat with nothing due: tuser %0d tdata %h tlast %0d",
                              m_axis_tuser, m_axis_tdata, m_axis_tlast));
      return;
    end
    want = due_beats.pop_front();
    got.kind       = m_axis_tuser;
    got.code_point = m_axis_tdata[20:0];
    got.red        = m_axis_tdata[28:21];
    got.green      = m_axis_tdata[36:29];
    got.blue       = m_axis_tdata[44:37];
    n_beats++;
    if (want.res.kind == KIND_CP) n_cp++;
    if (want.res.kind == KIND_CP && want.res.code_point == REPLACEMENT) n_repl++;
    if (want.res.kind == KIND_COLOUR) n_colour++;
    if (want.res.kind == KIND_END) n_end++;
    if (got.kind != want.res.kind)
      flag_mismatch($sformatf("beat %0d kind %0d, want %0d", n_beats, got.kind, want.res.kind));
    if (got.code_point != want.res.code_point)
      flag_mismatch($sformatf("beat %0d code point %h, want %h", n_beats, got.code_point,
                              want.res.code_point));
    if (got.red != want.res.red)
      flag_mismatch($sformatf("beat %0d red %h, want %h", n_beats, got.red, want.res.red));
    if (got.green != want.res.green)
      flag_mismatch($sformatf("beat %0d green %h, want %h", n_beats, got.green,
                              want.res.green));
    if (got.blue != want.res.blue)
      flag_mismatch($sformatf("beat %0d blue %h, want %h", n_beats, got.blue, want.res.blue));
    if (m_axis_tdata[47:45] != 3'b000)
      flag_mismatch($sformatf("beat %0d pad bits %b not zero", n_beats, m_axis_tdata[47:45]));
    if (m_axis_tlast != want.last)
      flag_mismatch($sformatf("beat %0d last_of_run %0d, want %0d", n_beats, m_axis_tlast,
                              want.last));
  endtask

  // Rising edge: note both handshakes, predict on input beats, check output beats
  always @(posedge clk) begin
    in_beat  = !rst && s_axis_tvalid && s_axis_tready;
    out_beat = !rst && m_axis_tvalid && m_axis_tready;
    if (in_beat) begin
      bytes_in++;
      parse_text_byte(s_axis_tdata, s_axis_tlast);
    end
    if (out_beat) check_result();
  end

  // ---------------------------------------------------------------------------
  // Driver: offers queued bytes, with a drawn gap after each
  // ---------------------------------------------------------------------------

  int tx_gap = 0;

  always @(negedge clk) begin : drive_proc
    bit next_ok;
    tx_item_t cur;
    if (!rst && (!s_axis_tvalid || in_beat)) begin
      next_ok = 1'b0;
      if (tx_gap > 0) tx_gap--;
      else if (text_queue.size() > 0) begin
        // a marked byte waits until every due result has been seen
        if (!(text_queue[0].drain_first && due_beats.size() != 0)) next_ok = 1'b1;
      end
      if (next_ok) begin
        cur = text_queue.pop_front();
        s_axis_tdata  <= cur.text_byte;
        s_axis_tlast  <= cur.eos;
        s_axis_tvalid <= 1'b1;
        tx_gap = $urandom_range(0, cur.gap_max);
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: drawn stall per beat, stall-free stretches, one long hold-off
  // ---------------------------------------------------------------------------

  int rx_wait = 0;
  int rx_max = 9;
  int rx_beats = 0;
  int rx_hold_left = 0;
  bit hold_done = 1'b0;

  always @(negedge clk) begin
    if (!hold_done && bytes_in >= HOLD_AT) begin
      hold_done = 1'b1;
      rx_hold_left = HOLD_CYCLES;
      longest_hold = HOLD_CYCLES;
    end
    if (out_beat) begin
      rx_beats++;
      if (rx_beats % 50 == 0) rx_max = $urandom_range(0, 1) ? 9 : 0;
      rx_wait = $urandom_range(0, rx_max);
    end
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (rx_hold_left > 0) begin
      rx_hold_left--;
      m_axis_tready <= 1'b0;
    end else if (rx_wait > 0) begin
      rx_wait--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus generation
  // ---------------------------------------------------------------------------

  task automatic push_byte(input logic [7:0] b, input logic eos, input bit counted = 1'b1);
    tx_item_t it;
    it.text_byte   = b;
    it.eos         = eos;
    it.drain_first = drain_next;
    drain_next     = 1'b0;
    // back-to-back bytes around the receiver hold-off so the block backs up
    if (text_queue.size() >= HOLD_AT - 5 && text_queue.size() < HOLD_AT + 60) it.gap_max = 0;
    else it.gap_max = gen_gap_max;
    text_queue.push_back(it);
    if (counted) gen_live++;
  endtask

  task automatic push_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) push_byte(8'(s[i]), 1'b0);
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] v);
    if (v < 4'd10) return 8'h30 + 8'(v);
    if ($urandom_range(0, 1)) return 8'h61 + 8'(v) - 8'd10;
    return 8'h41 + 8'(v) - 8'd10;
  endfunction

  function automatic logic [7:0] plain_char();
    logic [7:0] b;
    b = 8'($urandom_range(1, 127));
    if (b == CARET) b = 8'h20;
    return b;
  endfunction

  function automatic logic [7:0] cont_byte();
    return 8'h80 | 8'($urandom_range(0, 63));
  endfunction

  // One piece of a string: mostly well-formed, some broken
  task automatic add_token();
    int pick;
    int i;
    int k;
    int len;
    pick = $urandom_range(0, 12);
    case (pick)
      0, 1, 2: push_byte(plain_char(), 1'b0);
      3: begin
        push_byte(8'hC0 | 8'($urandom_range(0, 31)), 1'b0);
        push_byte(cont_byte(), 1'b0);
      end
      4: begin
        push_byte(8'hE0 | 8'($urandom_range(0, 15)), 1'b0);
        repeat (2) push_byte(cont_byte(), 1'b0);
      end
      5: begin
        push_byte(8'hF0 | 8'($urandom_range(0, 7)), 1'b0);
        repeat (3) push_byte(cont_byte(), 1'b0);
      end
      6: begin
        push_byte(CARET, 1'b0);
        push_byte(8'h30 + 8'($urandom_range(0, 9)), 1'b0);
      end
      7, 8: begin
        push_byte(CARET, 1'b0);
        push_byte(LETTER_X, 1'b0);
        repeat (6) push_byte(hex_char(4'($urandom_range(0, 15))), 1'b0);
      end
      9: begin
        // sequence cut short by a plain byte
        len = $urandom_range(2, 4);
        case (len)
          2: push_byte(8'hC0 | 8'($urandom_range(0, 31)), 1'b0);
          3: push_byte(8'hE0 | 8'($urandom_range(0, 15)), 1'b0);
          default: push_byte(8'hF0 | 8'($urandom_range(0, 7)), 1'b0);
        endcase
        k = $urandom_range(0, len - 2);
        for (i = 0; i < k; i++) push_byte(cont_byte(), 1'b0);
        push_byte(plain_char(), 1'b0);
      end
      10: begin
        // hex escape broken by a non-hex byte
        push_byte(CARET, 1'b0);
        push_byte(LETTER_X, 1'b0);
        k = $urandom_range(0, 5);
        for (i = 0; i < k; i++) push_byte(hex_char(4'($urandom_range(0, 15))), 1'b0);
        if ($urandom_range(0, 1)) push_byte(8'h67 + 8'($urandom_range(0, 19)), 1'b0);
        else push_byte(8'($urandom_range(1, 255)), 1'b0);
      end
      11: begin
        push_byte(CARET, 1'b0);
        push_byte(8'($urandom_range(1, 255)), 1'b0);
      end
      default: push_byte(8'($urandom_range(1, 255)), 1'b0);
    endcase
  endtask

  // A string of a few tokens and one of the ways a string can end
  task automatic add_string();
    int ntok;
    int tail;
    int k;
    logic [7:0] b;
    ntok = $urandom_range(1, 6);
    repeat (ntok) add_token();
    tail = $urandom_range(0, 9);
    if (tail < 6) begin
      case ($urandom_range(0, 3))
        0: b = 8'($urandom_range(0, 255));
        1: b = CARET;
        2: b = 8'($urandom_range(8'hC0, 8'hF7));
        default: b = LETTER_X;
      endcase
      push_byte(b, 1'b1);
    end else if (tail < 9) begin
      // zero terminator, then ignored bytes up to the next end flag
      push_byte(8'h00, 1'b0);
      k = $urandom_range(0, 3);
      repeat (k) push_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      push_byte(8'($urandom_range(0, 255)), 1'b1, 1'b0);
    end else begin
      push_byte(8'h00, 1'b1);
    end
  endtask

  initial begin
    bit drain_done;
    drain_done = 1'b0;

    // directed: ASCII, each sequence length, the largest codepoint
    push_byte(8'h41, 1'b0);
    push_byte(8'hC3, 1'b0); push_byte(8'hA9, 1'b0);
    push_byte(8'hE2, 1'b0); push_byte(8'h82, 1'b0); push_byte(8'hAC, 1'b0);
    push_byte(8'hF7, 1'b0); push_byte(8'hBF, 1'b0); push_byte(8'hBF, 1'b0);
    push_byte(8'hBF, 1'b0);
    // bad lead byte, then a lead with its continuation missing
    push_byte(8'hFF, 1'b0);
    push_byte(8'hC3, 1'b0); push_byte(8'h41, 1'b0);
    // palette, mixed-case hex, caret before a non-escape, broken hex escape
    push_text("^9^xFf00aB^q^xg");
    // zero byte inside a sequence ends the string; the rest is ignored
    push_byte(8'hE2, 1'b0); push_byte(8'h00, 1'b0);
    push_byte(8'h41, 1'b0, 1'b0); push_byte(8'h42, 1'b1, 1'b0);
    // incomplete escape at the end flag
    push_byte(CARET, 1'b1);

    // random strings, sender pauses for a full drain at their start and once more later
    drain_next = 1'b1;
    while (gen_live < 470) begin
      if ($urandom_range(0, 3) == 0) gen_gap_max = $urandom_range(0, 1) ? 9 : 0;
      if (!drain_done && gen_live > 330) begin
        drain_next = 1'b1;
        drain_done = 1'b1;
      end
      add_string();
    end

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (text_queue.size() != 0 || s_axis_tvalid) @(posedge clk);
    while (due_beats.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("checked %0d result beats from %0d text bytes: %0d codepoints (%0d U+FFFD),",
             n_beats, bytes_in, n_cp, n_repl);
    $display("  %0d colour changes, %0d end markers; one %0d-cycle receiver hold-off",
             n_colour, n_end, longest_hold);
    if (errors == 0) begin
      $display("utf8_escape_text_parser_top_tb: done, clean");
    end else begin
      $display("utf8_escape_text_parser_top_tb: done, errors");
    end
    $finish;
  end

  // Watchdog well beyond the slowest legal run
  initial begin
    #2000000;
    $display("utf8_escape_text_parser_top_tb: done, errors");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/u8esc_pkg.sv
rtl/u8esc_resolve.sv
rtl/utf8_escape_text_parser_top.sv
test/utf8_escape_text_parser_top_tb.sv
